// ===== rtl/windowed_byte_entropy_color_unit_macros.svh =====
// assertion macros for the windowed byte entropy color unit
// used by the port checker; no other dependencies
`ifndef WINDOWED_BYTE_ENTROPY_COLOR_UNIT_MACROS_SVH
`define WINDOWED_BYTE_ENTROPY_COLOR_UNIT_MACROS_SVH

// condition implies expression in the same cycle
`define WBEC_ASSERT_NOW(name, clk, rst_n, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// condition implies expression in the next cycle
`define WBEC_ASSERT_NEXT(name, clk, rst_n, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== rtl/wbec_pkg.sv =====
// shared constants, types and the entropy term table
// no dependencies
package wbec_pkg;

	localparam int WINDOW      = 32;
	localparam int HALF_WIN    = WINDOW / 2;
	localparam int NSYM        = 256;
	localparam int SYM_W       = 8;
	localparam int CNT_W       = $clog2(WINDOW + 1);
	localparam int RP_W        = $clog2(WINDOW);
	localparam int Q_W         = 17;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [Q_W-1:0] Q_ONE  = Q_W'(65536);
	localparam logic [Q_W-1:0] Q_HALF = Q_W'(32768);

	typedef struct packed {
		logic [Q_W-1:0] entropy;
		logic           first_fill;
		logic           last;
		logic           too_short;
	} job_t;

	// log2 in q16, fraction by repeated truncated squaring of a q30 mantissa
	function automatic longint unsigned log2_q16(input int unsigned n);
		int unsigned ip;
		longint unsigned y;
		longint unsigned frac;
		int k;
		ip = 0;
		frac = 0;
		if (n == 0) begin
			return 0;
		end
		while ((n >> ip) > 1) begin
			ip++;
		end
		y = longint'(n) << (30 - ip);
		for (k = 15; k >= 0; k--) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				frac = frac | (64'd1 << k);
			end
		end
		return (longint'(ip) << 16) | frac;
	endfunction

	localparam longint unsigned LOG_WIN  = log2_q16(WINDOW);
	localparam longint unsigned TERM_DEN = longint'(WINDOW) * LOG_WIN;

	typedef logic [Q_W-1:0] term_tab_t [WINDOW+1];

	function automatic term_tab_t build_terms();
		term_tab_t tab;
		longint unsigned lc;
		longint unsigned diff;
		int c;
		tab[0] = '0;
		for (c = 1; c <= WINDOW; c++) begin
			lc = log2_q16(c);
			diff = (LOG_WIN > lc) ? LOG_WIN - lc : 64'd0;
			tab[c] = Q_W'((longint'(c) * diff * 65536) / TERM_DEN);
		end
		return tab;
	endfunction

	localparam term_tab_t TERM_TAB = build_terms();

	function automatic logic [Q_W-1:0] term_of(input logic [CNT_W-1:0] c);
		return (int'(c) <= WINDOW) ? TERM_TAB[c] : '0;
	endfunction

endpackage

// ===== rtl/wbec_front.sv =====
// front end: takes bytes, keeps the window ring and histogram, tracks the entropy sum
// uses wbec_pkg; pushes one job per window result group into the queue
module wbec_front import wbec_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SYM_W-1:0] byte_value,
	input  logic             last_byte,
	output job_t             job,
	output logic             job_push,
	input  logic             job_full
);

	localparam logic [1:0] F_IDLE   = 2'd0;
	localparam logic [1:0] F_RD_OLD = 2'd1;
	localparam logic [1:0] F_WR_OLD = 2'd2;
	localparam logic [1:0] F_WR_NEW = 2'd3;

	logic [1:0]       state_q;
	logic [SYM_W-1:0] byte_q;
	logic             last_q;
	logic             fill_q;
	logic [CNT_W-1:0] seen_q;
	logic [RP_W-1:0]  rp_q;
	logic [Q_W-1:0]   sum_q;
	logic             fwd_q;
	logic [CNT_W-1:0] fwd_cnt_q;

	logic [SYM_W-1:0] win_mem [WINDOW];
	logic [SYM_W-1:0] win_rd_q;

	logic [CNT_W-1:0] hist_mem [NSYM];
	logic [CNT_W-1:0] hist_rd_q;
	logic [NSYM-1:0]  hist_vld_q;
	logic             hist_vld_rd_q;

	logic             accept;
	logic             evict;
	logic             hist_re;
	logic [SYM_W-1:0] hist_raddr;
	logic             hist_we;
	logic [SYM_W-1:0] hist_waddr;
	logic [CNT_W-1:0] hist_wdata;
	logic [CNT_W-1:0] cnt_rd;
	logic [CNT_W-1:0] cnt_new_cur;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] cnt_inc;
	logic [Q_W-1:0]   sum_old_nxt;
	logic [Q_W-1:0]   sum_new_nxt;
	logic [Q_W-1:0]   e_clamp;
	logic             is_full;
	logic             need_push;
	logic             commit;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign evict    = (seen_q == CNT_W'(WINDOW));
	assign is_full  = (seen_q == CNT_W'(WINDOW));

	assign cnt_rd      = hist_vld_rd_q ? hist_rd_q : '0;
	assign cnt_new_cur = fwd_q ? fwd_cnt_q : cnt_rd;
	assign cnt_dec     = (cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;
	assign cnt_inc     = (cnt_new_cur < CNT_W'(WINDOW)) ? cnt_new_cur + 1'b1 : cnt_new_cur;
	assign sum_old_nxt = sum_q - term_of(cnt_rd) + term_of(cnt_dec);
	assign sum_new_nxt = sum_q - term_of(cnt_new_cur) + term_of(cnt_inc);
	assign e_clamp     = (sum_new_nxt > Q_ONE) ? Q_ONE : sum_new_nxt;

	assign need_push = is_full || last_q;
	assign commit    = (state_q == F_WR_NEW) && (!need_push || !job_full);
	assign job_push  = commit && need_push;

	always_comb begin
		job.entropy    = is_full ? e_clamp : '0;
		job.first_fill = fill_q;
		job.last       = last_q;
		job.too_short  = !is_full;
	end

	always_comb begin
		hist_re    = 1'b0;
		hist_raddr = byte_value;
		hist_we    = 1'b0;
		hist_waddr = byte_q;
		hist_wdata = cnt_inc;
		unique case (state_q)
			F_IDLE: begin
				hist_re    = accept && !evict;
				hist_raddr = byte_value;
			end
			F_RD_OLD: begin
				hist_re    = 1'b1;
				hist_raddr = win_rd_q;
			end
			F_WR_OLD: begin
				hist_re    = 1'b1;
				hist_raddr = byte_q;
				hist_we    = 1'b1;
				hist_waddr = win_rd_q;
				hist_wdata = cnt_dec;
			end
			F_WR_NEW: begin
				hist_we    = commit;
				hist_waddr = byte_q;
				hist_wdata = cnt_inc;
			end
			default: begin
				hist_re = 1'b0;
			end
		endcase
	end

	// window ring, read before write at the same slot
	always_ff @(posedge clk) begin
		if (accept) begin
			win_mem[rp_q] <= byte_value;
			win_rd_q      <= win_mem[rp_q];
		end
	end

	// histogram counts
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[hist_raddr];
		end
	end

	// histogram valid bits, cleared at reset and at chunk end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q    <= '0;
			hist_vld_rd_q <= 1'b0;
		end else begin
			if (hist_re) begin
				hist_vld_rd_q <= hist_vld_q[hist_raddr];
			end
			if (commit && last_q) begin
				hist_vld_q <= '0;
			end else if (hist_we) begin
				hist_vld_q[hist_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= byte_value;
			last_q <= last_byte;
			fill_q <= !evict && (seen_q == CNT_W'(WINDOW - 1));
		end
		if (state_q == F_WR_OLD) begin
			fwd_cnt_q <= cnt_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			seen_q  <= '0;
			rp_q    <= '0;
			sum_q   <= '0;
			fwd_q   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						rp_q  <= (rp_q == RP_W'(WINDOW - 1)) ? '0 : rp_q + 1'b1;
						fwd_q <= 1'b0;
						if (evict) begin
							state_q <= F_RD_OLD;
						end else begin
							seen_q  <= seen_q + 1'b1;
							state_q <= F_WR_NEW;
						end
					end
				end
				F_RD_OLD: begin
					state_q <= F_WR_OLD;
				end
				F_WR_OLD: begin
					sum_q   <= sum_old_nxt;
					fwd_q   <= (byte_q == win_rd_q);
					state_q <= F_WR_NEW;
				end
				F_WR_NEW: begin
					if (commit) begin
						state_q <= F_IDLE;
						if (last_q) begin
							sum_q  <= '0;
							seen_q <= '0;
							rp_q   <= '0;
						end else begin
							sum_q <= sum_new_nxt;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/wbec_queue.sv =====
// short job queue between the front and back ends
// uses wbec_pkg for the job type and depth
module wbec_queue import wbec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_job,
	input  logic push,
	output logic full,
	output job_t pop_job,
	output logic pop_valid,
	input  logic pop
);

	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t               slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wbec_back.sv =====
// back end: red and blue curves through registered multiplies, then result emission
// uses wbec_pkg; takes jobs from the queue
module wbec_back import wbec_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  job_t           job,
	input  logic           job_valid,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [Q_W-1:0] entropy_value,
	output logic [Q_W-1:0] red_value,
	output logic [Q_W-1:0] blue_value,
	output logic           last_result,
	output logic           too_short
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL1 = 3'd1;
	localparam logic [2:0] B_MUL2 = 3'd2;
	localparam logic [2:0] B_MUL3 = 3'd3;
	localparam logic [2:0] B_EMIT = 3'd4;

	localparam int V_W = Q_W - 1;
	localparam int P_W = 2 * Q_W;

	logic [2:0]       state_q;
	job_t             job_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	logic [V_W-1:0]   v_s1;
	logic [2*V_W-1:0] vv_s1;
	logic [Q_W-1:0]   blue_s1;
	logic [Q_W-1:0]   q2_s2;
	logic [Q_W-1:0]   red_s3;

	logic [V_W-1:0]   v;
	logic [P_W-1:0]   ee;
	logic [V_W-1:0]   diff;
	logic [Q_W-1:0]   q;
	logic [P_W-1:0]   qq;
	logic [P_W-1:0]   rr;
	logic [CNT_W-1:0] n_res;
	logic             load;

	assign v    = (job_q.entropy > Q_HALF) ? V_W'(job_q.entropy - Q_HALF) : '0;
	assign ee   = P_W'(job_q.entropy) * P_W'(job_q.entropy);
	assign diff = v_s1 - vv_s1[2*V_W-1:V_W];
	assign q    = {diff[Q_W-3:0], 2'b00};
	assign qq   = P_W'(q) * P_W'(q);
	assign rr   = P_W'(q2_s2) * P_W'(q2_s2);

	always_comb begin
		priority if (job_q.too_short) begin
			n_res = CNT_W'(1);
		end else begin
			n_res = (job_q.first_fill ? CNT_W'(HALF_WIN + 1) : CNT_W'(1))
				+ (job_q.last ? CNT_W'(WINDOW - HALF_WIN - 1) : CNT_W'(0));
		end
	end

	assign job_pop   = (state_q == B_IDLE) && job_valid;
	assign load      = (state_q == B_EMIT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == B_MUL1) begin
			v_s1    <= v;
			vv_s1   <= v * v;
			blue_s1 <= ee[Q_W+15:16];
		end
		if (state_q == B_MUL2) begin
			q2_s2 <= qq[Q_W+15:16];
		end
		if (state_q == B_MUL3) begin
			red_s3 <= rr[Q_W+15:16];
		end
		if (load) begin
			entropy_value <= job_q.entropy;
			red_value     <= red_s3;
			blue_value    <= blue_s1;
			last_result   <= job_q.last && (cnt_q == CNT_W'(1));
			too_short     <= job_q.too_short;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= B_MUL1;
					end
				end
				B_MUL1: begin
					state_q <= B_MUL2;
				end
				B_MUL2: begin
					state_q <= B_MUL3;
				end
				B_MUL3: begin
					cnt_q   <= n_res;
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (load) begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CNT_W'(1)) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/windowed_byte_entropy_color_unit.sv =====
// top level of the windowed byte entropy color unit
// uses wbec_pkg, wbec_front, wbec_queue and wbec_back
//
// channel | signals                                           | moves
// in      | in_valid, in_ready, byte_value, last_byte         | one chunk byte per item
// out     | out_valid, out_ready, entropy_value, red_value,   | one window result per item
//         | blue_value, last_result, too_short                |
//
// a byte passes idle and write-new while the window fills, plus read-old and write-old
// once full: a histogram read-modify-write for the new byte and any evicted one, each
// with a registered read; a result group passes mul1, mul2 and mul3, then results leave
// at one per cycle while out_ready is high; histogram valid bits clear at reset and at
// chunk end, so no clearing pass; a two-entry queue lets bytes go on while results stall
module windowed_byte_entropy_color_unit import wbec_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SYM_W-1:0] byte_value,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Q_W-1:0]   entropy_value,
	output logic [Q_W-1:0]   red_value,
	output logic [Q_W-1:0]   blue_value,
	output logic             last_result,
	output logic             too_short
);

	job_t push_job;
	job_t pop_job;
	logic push;
	logic full;
	logic pop_valid;
	logic pop;

	wbec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.job        (push_job),
		.job_push   (push),
		.job_full   (full)
	);

	wbec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_job  (push_job),
		.push      (push),
		.full      (full),
		.pop_job   (pop_job),
		.pop_valid (pop_valid),
		.pop       (pop)
	);

	wbec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (pop_job),
		.job_valid     (pop_valid),
		.job_pop       (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entropy_value (entropy_value),
		.red_value     (red_value),
		.blue_value    (blue_value),
		.last_result   (last_result),
		.too_short     (too_short)
	);

endmodule

// ===== rtl/wbec_checker.sv =====
// port checker for the windowed byte entropy color unit, bound to the top level
// uses wbec_pkg and windowed_byte_entropy_color_unit_macros.svh
`include "windowed_byte_entropy_color_unit_macros.svh"

module wbec_checker import wbec_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input logic [Q_W-1:0] entropy_value,
	input logic [Q_W-1:0] red_value,
	input logic [Q_W-1:0] blue_value,
	input logic           last_result,
	input logic           too_short
);

	`WBEC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(entropy_value) && $stable(last_result), "stalled result item changed")
	`WBEC_ASSERT_NOW(a_short_item, clk, arst_n, out_valid && too_short, last_result && entropy_value == '0 && red_value == '0 && blue_value == '0, "short chunk item malformed")
	`WBEC_ASSERT_NOW(a_red_band, clk, arst_n, out_valid && red_value != '0, entropy_value > Q_HALF, "red set at low entropy")
	`WBEC_ASSERT_NOW(a_range, clk, arst_n, out_valid, entropy_value <= Q_ONE && blue_value <= entropy_value, "entropy or blue out of range")

endmodule

bind windowed_byte_entropy_color_unit wbec_checker u_wbec_checker (.*);
